// ===== sv/ecpu_pkg.sv =====
// ----------------------------------------------------------------------------
// ecpu_pkg: shared types and constants of the eight-bit accumulator CPU
// Command codes, opcodes, controller-to-datapath command and status bundles,
// and the layout of one result item.
// ----------------------------------------------------------------------------
package ecpu_pkg;

  localparam int unsigned MemDepth = 16;
  localparam int unsigned AddrW    = $clog2(MemDepth);

  // Host command codes carried in the input tuser field.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_EXEC  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Opcodes in the high nibble of an instruction byte.
  localparam logic [3:0] OP_NOP = 4'h0;
  localparam logic [3:0] OP_LDA = 4'h1;
  localparam logic [3:0] OP_ADD = 4'h2;
  localparam logic [3:0] OP_SUB = 4'h3;
  localparam logic [3:0] OP_STA = 4'h4;
  localparam logic [3:0] OP_LDI = 4'h5;
  localparam logic [3:0] OP_JMP = 4'h6;
  localparam logic [3:0] OP_JC  = 4'h7;
  localparam logic [3:0] OP_JZ  = 4'h8;
  localparam logic [3:0] OP_OUT = 4'hE;
  localparam logic [3:0] OP_HLT = 4'hF;

  // Reported instruction lengths in clock cycles.
  localparam logic [2:0] CYC_INSTR = 3'd5;
  localparam logic [2:0] CYC_HALT  = 3'd3;

  // Source of the memory read address.
  typedef enum logic [1:0] {
    RD_HOST,
    RD_PC,
    RD_OPND
  } rd_sel_e;

  typedef struct packed {
    logic    item_start;
    logic    wr_host;
    logic    clr_regs;
    rd_sel_e rd_sel;
    logic    fetch;
    logic    exec;
    logic    cap_read;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic halted;
  } dp_status_t;

  // One result item, out_value in the lowest bits.
  typedef struct packed {
    logic [3:0]       pad;
    logic [7:0]       read_data;
    logic             zero_flag;
    logic             carry_flag;
    logic [7:0]       accum;
    logic [AddrW-1:0] prog_counter;
    logic [2:0]       cycle_count;
    logic             illegal;
    logic             halted;
    logic             out_strobe;
    logic [7:0]       out_value;
  } result_t;

endpackage

// ===== sv/ecpu_ctrl.sv =====
// ----------------------------------------------------------------------------
// ecpu_ctrl: sequencing controller of the eight-bit accumulator CPU
// Accepts host items, steps fetch and execute through the datapath and
// hands finished results to the output register.
// ----------------------------------------------------------------------------
module ecpu_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             cmd_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  ecpu_pkg::dp_status_t   status_i,
  output ecpu_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_READ,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = ecpu_pkg::RD_HOST;
    state_d      = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.item_start = 1'b1;
          unique case (cmd_i)
            ecpu_pkg::CMD_WRITE: begin
              cmd_o.wr_host = 1'b1;
              state_d       = S_DONE;
            end
            ecpu_pkg::CMD_CLEAR: begin
              cmd_o.clr_regs = 1'b1;
              state_d        = S_DONE;
            end
            ecpu_pkg::CMD_READ: begin
              state_d = S_READ;
            end
            ecpu_pkg::CMD_EXEC: begin
              // A halted machine does not execute: the item changes nothing.
              if (status_i.halted) begin
                state_d = S_DONE;
              end else begin
                cmd_o.rd_sel = ecpu_pkg::RD_PC;
                state_d      = S_FETCH;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_FETCH: begin
        cmd_o.fetch  = 1'b1;
        cmd_o.rd_sel = ecpu_pkg::RD_OPND;
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_DONE;
      end
      S_READ: begin
        cmd_o.cap_read = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.load_out) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// ===== sv/ecpu_dp.sv =====
// ----------------------------------------------------------------------------
// ecpu_dp: datapath of the eight-bit accumulator CPU
// Unified program and data memory, registers, ALU and the result register.
// ----------------------------------------------------------------------------
module ecpu_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [ecpu_pkg::AddrW-1:0]     addr_i,
  input  logic [7:0]                     wdata_i,
  input  ecpu_pkg::ctrl_cmd_t            cmd_i,
  output ecpu_pkg::dp_status_t           status_o,
  output ecpu_pkg::result_t              result_o
);

  localparam int unsigned AW = ecpu_pkg::AddrW;

  // Memory and per-entry valid bits; an entry never written reads as zero (NOP).
  logic [7:0]                  mem_q [ecpu_pkg::MemDepth];
  logic [ecpu_pkg::MemDepth-1:0] vld_q;
  logic [7:0]                  rdata_q;
  logic                        rvld_q;
  logic [7:0]                  rd_word;
  logic [AW-1:0]               raddr;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [7:0]                  wdat;

  logic [AW-1:0] pc_q, pc_d;
  logic [7:0]    acc_q, acc_d;
  logic [7:0]    b_q, b_d;
  logic [7:0]    out_q, out_d;
  logic          carry_q, carry_d;
  logic          zero_q, zero_d;
  logic          halt_q, halt_d;
  logic [7:0]    ir_q, ir_d;

  logic          strobe_q, strobe_d;
  logic          bad_q, bad_d;
  logic [2:0]    cyc_q, cyc_d;
  logic [7:0]    rdat_q, rdat_d;
  ecpu_pkg::result_t res_q;

  logic [3:0]    opcode;
  logic [AW-1:0] opnd;
  logic [7:0]    b_src;
  logic [8:0]    sum;

  assign rd_word = rvld_q ? rdata_q : 8'h00;
  assign opcode  = ir_q[7:4];
  assign opnd    = ir_q[AW-1:0];

  always_comb begin
    unique case (cmd_i.rd_sel)
      ecpu_pkg::RD_PC:   raddr = pc_q;
      ecpu_pkg::RD_OPND: raddr = rd_word[AW-1:0];
      default:           raddr = addr_i;
    endcase
  end

  // SUB adds the two's complement of the operand.
  assign b_src = (opcode == ecpu_pkg::OP_SUB) ? 8'(8'd0 - rd_word) : rd_word;
  assign sum   = {1'b0, acc_q} + {1'b0, b_src};

  always_comb begin
    pc_d     = pc_q;
    acc_d    = acc_q;
    b_d      = b_q;
    out_d    = out_q;
    carry_d  = carry_q;
    zero_d   = zero_q;
    halt_d   = halt_q;
    ir_d     = ir_q;
    strobe_d = strobe_q;
    bad_d    = bad_q;
    cyc_d    = cyc_q;
    rdat_d   = rdat_q;
    we       = 1'b0;
    waddr    = addr_i;
    wdat     = wdata_i;

    if (cmd_i.item_start) begin
      strobe_d = 1'b0;
      bad_d    = 1'b0;
      cyc_d    = 3'd0;
      rdat_d   = 8'h00;
    end
    if (cmd_i.wr_host) begin
      we = 1'b1;
    end
    if (cmd_i.clr_regs) begin
      pc_d    = '0;
      acc_d   = 8'h00;
      b_d     = 8'h00;
      out_d   = 8'h00;
      carry_d = 1'b0;
      zero_d  = 1'b0;
      halt_d  = 1'b0;
    end
    if (cmd_i.cap_read) begin
      rdat_d = rd_word;
    end
    if (cmd_i.fetch) begin
      ir_d = rd_word;
      pc_d = pc_q + AW'(1);
    end
    if (cmd_i.exec) begin
      cyc_d = ecpu_pkg::CYC_INSTR;
      unique case (opcode)
        ecpu_pkg::OP_NOP: ;
        ecpu_pkg::OP_LDA: acc_d = rd_word;
        ecpu_pkg::OP_ADD,
        ecpu_pkg::OP_SUB: begin
          b_d     = rd_word;
          acc_d   = sum[7:0];
          carry_d = sum[8];
          zero_d  = (sum[7:0] == 8'h00);
        end
        ecpu_pkg::OP_STA: begin
          we    = 1'b1;
          waddr = opnd;
          wdat  = acc_q;
        end
        ecpu_pkg::OP_LDI: acc_d = {4'h0, ir_q[3:0]};
        ecpu_pkg::OP_JMP: pc_d = opnd;
        ecpu_pkg::OP_JC:  if (carry_q) pc_d = opnd;
        ecpu_pkg::OP_JZ:  if (zero_q) pc_d = opnd;
        ecpu_pkg::OP_OUT: begin
          out_d    = acc_q;
          strobe_d = 1'b1;
        end
        ecpu_pkg::OP_HLT: begin
          cyc_d  = ecpu_pkg::CYC_HALT;
          halt_d = 1'b1;
        end
        default: bad_d = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdat;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rvld_q  <= 1'b0;
      pc_q    <= '0;
      acc_q   <= 8'h00;
      b_q     <= 8'h00;
      out_q   <= 8'h00;
      carry_q <= 1'b0;
      zero_q  <= 1'b0;
      halt_q  <= 1'b0;
    end else begin
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      rvld_q  <= vld_q[raddr];
      pc_q    <= pc_d;
      acc_q   <= acc_d;
      b_q     <= b_d;
      out_q   <= out_d;
      carry_q <= carry_d;
      zero_q  <= zero_d;
      halt_q  <= halt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ir_q     <= ir_d;
    strobe_q <= strobe_d;
    bad_q    <= bad_d;
    cyc_q    <= cyc_d;
    rdat_q   <= rdat_d;
    if (cmd_i.load_out) begin
      res_q.pad          <= 4'h0;
      res_q.read_data    <= rdat_q;
      res_q.zero_flag    <= zero_q;
      res_q.carry_flag   <= carry_q;
      res_q.accum        <= acc_q;
      res_q.prog_counter <= pc_q;
      res_q.cycle_count  <= cyc_q;
      res_q.illegal      <= bad_q;
      res_q.halted       <= halt_q;
      res_q.out_strobe   <= strobe_q;
      res_q.out_value    <= out_q;
    end
  end

  assign status_o.halted = halt_q;
  assign result_o        = res_q;

endmodule

// ===== sv/eight_bit_accumulator_cpu.sv =====
// ----------------------------------------------------------------------------
// eight_bit_accumulator_cpu: tiny accumulator CPU with a 16-byte memory
// Host items write or read a memory byte, clear the registers, or execute
// one instruction; each item returns one status item.
// ----------------------------------------------------------------------------
// Each input item produces exactly one result item. The block works on one
// item at a time, stepped by a controller through a single memory with a
// registered read port. A write or register clear goes from accept straight
// to the result load, a memory read passes a read-capture state first, and an
// executed instruction takes fetch read, operand read, execute and result
// load in order. A halted CPU answers an execute directly and changes
// nothing. The result register lets the next item be accepted while the
// previous result still waits on the output. Memory reads as all zeros after
// reset through per-byte valid bits, so no clearing pass is needed.
module eight_bit_accumulator_cpu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [3:0] addr, [11:4] wdata, [15:12] zero
  input  logic [15:0] s_axis_tdata_i,
  // [1:0] cmd
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] out_value, [8] out_strobe, [9] halted, [10] illegal,
  // [13:11] cycle_count, [17:14] prog_counter, [25:18] accum,
  // [26] carry_flag, [27] zero_flag, [35:28] read_data, [39:36] zero
  output logic [39:0] m_axis_tdata_o
);

  ecpu_pkg::ctrl_cmd_t  ctrl_cmd;
  ecpu_pkg::dp_status_t dp_status;
  ecpu_pkg::result_t    result;

  ecpu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .cmd_i       (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (dp_status),
    .cmd_o       (ctrl_cmd)
  );

  ecpu_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .addr_i   (s_axis_tdata_i[ecpu_pkg::AddrW-1:0]),
    .wdata_i  (s_axis_tdata_i[11:4]),
    .cmd_i    (ctrl_cmd),
    .status_o (dp_status),
    .result_o (result)
  );

  assign m_axis_tdata_o = result;

  // An accepted item keeps the input closed for at least the next cycle.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input ready right after an accepted item");

  // A new result is never loaded over one that is still waiting.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.load_out |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result register overwritten while stalled");

  // An illegal opcode is still a full-length executed instruction.
  a_illegal_cycles : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && result.illegal) |-> (result.cycle_count == ecpu_pkg::CYC_INSTR))
    else $error("illegal opcode reported with wrong cycle count");

endmodule
